// ===== rtl/sgv_pkg.sv =====
// Types, constants and the sat32 helper shared by the spring grid Verlet step block.
package sgv_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPRING_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE    = 2'd1;

  localparam logic [DATA_W-1:0] SPRING_COEFF_RST = 32'd429;
  localparam logic [DATA_W-1:0] VEL_SCALE_RST    = 32'd327680000;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD_PREV,
    ST_LOAD_CURR,
    ST_READ_ISSUE,
    ST_READ_OUT,
    ST_SC_CENTER,
    ST_SC_COPY,
    ST_SC_VERT,
    ST_SC_HORZ,
    ST_SC_LAP,
    ST_SC_KABS,
    ST_SC_KHI,
    ST_SC_KLO,
    ST_SC_NEW,
    ST_SC_VABS,
    ST_SC_VHI,
    ST_SC_VLO,
    ST_SC_WB
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_NODE,
    RD_CENTER,
    RD_VERT,
    RD_HORZ
  } rd_e;

  typedef enum logic [1:0] {
    WR_LD_PREV,
    WR_LD_CURR,
    WR_COPY,
    WR_NEW
  } wr_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_SUM_VERT,
    DP_LAP,
    DP_KABS,
    DP_MUL_HI,
    DP_MUL_LO,
    DP_NEW,
    DP_VABS
  } dp_op_e;

  typedef struct packed {
    logic   capture;
    rd_e    rd_kind;
    logic   pos_we;
    wr_e    wsel;
    logic   vel_we;
    logic   vel_clear;
    dp_op_e dp_op;
    logic   fsel_vel;
    logic   out_load;
    logic   scan_clear;
    logic   scan_next;
    logic   rotate;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       on_grid;
    logic       border;
    logic       scan_last;
    logic       clr_last;
    logic       out_busy;
  } status_t;

  function automatic logic [DATA_W-1:0] sat32(logic signed [55:0] v);
    logic [DATA_W-1:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -56'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sgv_if.sv =====
// Channel interfaces for items, results and register writes.
interface sgv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  row;
  logic [3:0]  col;
  logic        axis;
  logic signed [31:0] prev_value;
  logic signed [31:0] curr_value;
  modport source (output valid, op, row, col, axis, prev_value, curr_value, input ready);
  modport sink (input valid, op, row, col, axis, prev_value, curr_value, output ready);
endinterface

interface sgv_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  modport source (output valid, position, velocity, input ready);
  modport sink (input valid, position, velocity, output ready);
endinterface

interface sgv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/spring_grid_verlet_step.sv =====
// Top level: mass-spring grid advanced by position Verlet over three rotating banks.
// A load passes dispatch and two write states; a read issues the memory read and then
// waits for the result register. A step is paced by the two-read position memory and
// the shared 35x16 multiplier, used twice for each of the two products of an inner node.
// After reset a clearing pass over all 2*N^2 entries zeroes the velocity memory; no item is
// accepted during it, while register writes are taken at any time.
module spring_grid_verlet_step #(
  parameter int GRID_SIDE = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgv_in_if.sink     in_i,
  sgv_out_if.source  out_o,
  sgv_cfg_if.sink    cfg_i
);
  import sgv_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  sgv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  sgv_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (in_i.op),
    .row_i        (in_i.row),
    .col_i        (in_i.col),
    .axis_i       (in_i.axis),
    .prev_value_i (in_i.prev_value),
    .curr_value_i (in_i.curr_value),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .position_o   (out_o.position),
    .velocity_o   (out_o.velocity)
  );

endmodule

// ===== rtl/sgv_ctrl.sv =====
// Controller state machine that sequences loads, reads and the grid step.
module sgv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  sgv_pkg::status_t status_i,
  output logic             in_ready_o,
  output sgv_pkg::cmd_t    cmd_o
);
  import sgv_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (status_i.op)
          OP_LOAD: state_d = status_i.on_grid ? ST_LOAD_PREV : ST_IDLE;
          OP_STEP: state_d = ST_SC_CENTER;
          OP_READ: state_d = ST_READ_ISSUE;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_LOAD_PREV: state_d = ST_LOAD_CURR;
      ST_LOAD_CURR: state_d = ST_IDLE;
      ST_READ_ISSUE: state_d = ST_READ_OUT;
      ST_READ_OUT: if (!status_i.out_busy) state_d = ST_IDLE;
      ST_SC_CENTER: state_d = status_i.border ? ST_SC_COPY : ST_SC_VERT;
      ST_SC_COPY: state_d = status_i.scan_last ? ST_IDLE : ST_SC_CENTER;
      ST_SC_VERT: state_d = ST_SC_HORZ;
      ST_SC_HORZ: state_d = ST_SC_LAP;
      ST_SC_LAP: state_d = ST_SC_KABS;
      ST_SC_KABS: state_d = ST_SC_KHI;
      ST_SC_KHI: state_d = ST_SC_KLO;
      ST_SC_KLO: state_d = ST_SC_NEW;
      ST_SC_NEW: state_d = ST_SC_VABS;
      ST_SC_VABS: state_d = ST_SC_VHI;
      ST_SC_VHI: state_d = ST_SC_VLO;
      ST_SC_VLO: state_d = ST_SC_WB;
      ST_SC_WB: state_d = status_i.scan_last ? ST_IDLE : ST_SC_CENTER;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_kind = RD_NONE;
    cmd_o.wsel    = WR_NEW;
    cmd_o.dp_op   = DP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.vel_we    = 1'b1;
        cmd_o.vel_clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DISPATCH: cmd_o.scan_clear = 1'b1;
      ST_LOAD_PREV: begin
        cmd_o.pos_we = 1'b1;
        cmd_o.wsel   = WR_LD_PREV;
      end
      ST_LOAD_CURR: begin
        cmd_o.pos_we = 1'b1;
        cmd_o.wsel   = WR_LD_CURR;
      end
      ST_READ_ISSUE: cmd_o.rd_kind = RD_NODE;
      ST_READ_OUT: cmd_o.out_load = !status_i.out_busy;
      ST_SC_CENTER: cmd_o.rd_kind = RD_CENTER;
      ST_SC_COPY: begin
        cmd_o.pos_we    = 1'b1;
        cmd_o.wsel      = WR_COPY;
        cmd_o.scan_next = 1'b1;
        cmd_o.rotate    = status_i.scan_last;
      end
      ST_SC_VERT: begin
        cmd_o.rd_kind = RD_VERT;
        cmd_o.dp_op   = DP_CAPTURE;
      end
      ST_SC_HORZ: begin
        cmd_o.rd_kind = RD_HORZ;
        cmd_o.dp_op   = DP_SUM_VERT;
      end
      ST_SC_LAP: cmd_o.dp_op = DP_LAP;
      ST_SC_KABS: cmd_o.dp_op = DP_KABS;
      ST_SC_KHI: cmd_o.dp_op = DP_MUL_HI;
      ST_SC_KLO: cmd_o.dp_op = DP_MUL_LO;
      ST_SC_NEW: cmd_o.dp_op = DP_NEW;
      ST_SC_VABS: cmd_o.dp_op = DP_VABS;
      ST_SC_VHI: begin
        cmd_o.dp_op    = DP_MUL_HI;
        cmd_o.fsel_vel = 1'b1;
      end
      ST_SC_VLO: begin
        cmd_o.dp_op    = DP_MUL_LO;
        cmd_o.fsel_vel = 1'b1;
      end
      ST_SC_WB: begin
        cmd_o.pos_we    = 1'b1;
        cmd_o.wsel      = WR_NEW;
        cmd_o.vel_we    = 1'b1;
        cmd_o.scan_next = 1'b1;
        cmd_o.rotate    = status_i.scan_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sgv_dp.sv =====
// Datapath with position and velocity memories, scan counters and the Verlet arithmetic.
module sgv_dp #(
  parameter int GRID_SIDE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgv_pkg::cmd_t    cmd_i,
  output sgv_pkg::status_t status_o,
  input  logic [1:0]       op_i,
  input  logic [3:0]       row_i,
  input  logic [3:0]       col_i,
  input  logic             axis_i,
  input  logic [31:0]      prev_value_i,
  input  logic [31:0]      curr_value_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      position_o,
  output logic [31:0]      velocity_o
);
  import sgv_pkg::*;

  localparam int PLANE = GRID_SIDE * GRID_SIDE;
  localparam int BANK  = 2 * PLANE;
  localparam int DEPTH = 3 * BANK;
  localparam int IW    = $clog2(BANK);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_SIDE);

  logic [31:0] coeff_q, vscale_q;
  logic [1:0]  op_q;
  logic [3:0]  row_q, col_q;
  logic        axis_q;
  logic [31:0] prev_q, curr_q;
  logic [1:0]  rot_q, cur_bank, nxt_bank;
  logic [IW-1:0] idx_q, clr_q, in_idx;
  logic [CW-1:0] sr_q, sc_q;
  logic [31:0] pos_mem [DEPTH];
  logic [31:0] vel_mem [BANK];
  logic [31:0] rda_q, rdb_q, velrd_q;
  logic [AW-1:0] addr_a, addr_b, waddr;
  logic [31:0] wdata;
  logic        ren_a, ren_b, ren_v;
  logic [IW-1:0] vaddr;
  logic [31:0] vdata;
  logic [31:0] cv_q, pv_q, nv_q;
  logic signed [32:0] sum_q;
  logic signed [35:0] lap_q, lap_neg, four_cv, sum4;
  logic [34:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [51:0] acc_q;
  logic [15:0] fpart;
  logic [50:0] prod;
  logic signed [39:0] term_s, nv_full;
  logic signed [34:0] vdiff, vdiff_neg;
  logic signed [55:0] vel_s;
  logic [31:0] vel_res;
  logic        out_valid_q;
  logic        on_grid;

  function automatic logic [AW-1:0] bank_addr(logic [1:0] b, logic [IW-1:0] i);
    logic [AW-1:0] base;
    case (b)
      2'd0: base = '0;
      2'd1: base = AW'(BANK);
      default: base = AW'(2 * BANK);
    endcase
    return base + AW'(i);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q  <= SPRING_COEFF_RST;
      vscale_q <= VEL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SPRING_COEFF: coeff_q <= cfg_data_i;
        REG_VEL_SCALE: vscale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      row_q  <= row_i;
      col_q  <= col_i;
      axis_q <= axis_i;
      prev_q <= prev_value_i;
      curr_q <= curr_value_i;
    end
  end

  assign on_grid  = (32'(row_q) < 32'(GRID_SIDE)) && (32'(col_q) < 32'(GRID_SIDE));
  assign in_idx   = (axis_q ? IW'(PLANE) : '0) + IW'(row_q) * IW'(GRID_SIDE) + IW'(col_q);
  assign cur_bank = (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
  assign nxt_bank = (cur_bank == 2'd2) ? 2'd0 : cur_bank + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= 2'd0;
      clr_q <= '0;
      idx_q <= '0;
      sr_q  <= '0;
      sc_q  <= '0;
    end else begin
      if (cmd_i.rotate) rot_q <= cur_bank;
      if (cmd_i.vel_clear) clr_q <= clr_q + IW'(1);
      if (cmd_i.scan_clear) begin
        idx_q <= '0;
        sr_q  <= '0;
        sc_q  <= '0;
      end else if (cmd_i.scan_next) begin
        idx_q <= idx_q + IW'(1);
        if (sc_q == CW'(GRID_SIDE - 1)) begin
          sc_q <= '0;
          sr_q <= (sr_q == CW'(GRID_SIDE - 1)) ? '0 : sr_q + CW'(1);
        end else begin
          sc_q <= sc_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    addr_a = bank_addr(cur_bank, idx_q);
    addr_b = bank_addr(rot_q, idx_q);
    ren_a  = 1'b0;
    ren_b  = 1'b0;
    ren_v  = 1'b0;
    case (cmd_i.rd_kind)
      RD_NODE: begin
        addr_a = bank_addr(cur_bank, in_idx);
        ren_a  = 1'b1;
        ren_v  = 1'b1;
      end
      RD_CENTER: begin
        ren_a = 1'b1;
        ren_b = 1'b1;
      end
      RD_VERT: begin
        addr_a = bank_addr(cur_bank, idx_q - IW'(GRID_SIDE));
        addr_b = bank_addr(cur_bank, idx_q + IW'(GRID_SIDE));
        ren_a  = 1'b1;
        ren_b  = 1'b1;
      end
      RD_HORZ: begin
        addr_a = bank_addr(cur_bank, idx_q - IW'(1));
        addr_b = bank_addr(cur_bank, idx_q + IW'(1));
        ren_a  = 1'b1;
        ren_b  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_i.wsel)
      WR_LD_PREV: begin
        waddr = bank_addr(rot_q, in_idx);
        wdata = prev_q;
      end
      WR_LD_CURR: begin
        waddr = bank_addr(cur_bank, in_idx);
        wdata = curr_q;
      end
      WR_COPY: begin
        waddr = bank_addr(nxt_bank, idx_q);
        wdata = rda_q;
      end
      default: begin
        waddr = bank_addr(nxt_bank, idx_q);
        wdata = nv_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_we) pos_mem[waddr] <= wdata;
    if (ren_a) rda_q <= pos_mem[addr_a];
    if (ren_b) rdb_q <= pos_mem[addr_b];
  end

  assign vaddr = cmd_i.vel_clear ? clr_q : idx_q;
  assign vdata = cmd_i.vel_clear ? '0 : vel_res;

  always_ff @(posedge clk_i) begin
    if (cmd_i.vel_we) vel_mem[vaddr] <= vdata;
    if (ren_v) velrd_q <= vel_mem[in_idx];
  end

  assign four_cv   = {{2{cv_q[31]}}, cv_q, 2'b00};
  assign sum4      = {{3{sum_q[32]}}, sum_q} + {{4{rda_q[31]}}, rda_q}
                   + {{4{rdb_q[31]}}, rdb_q};
  assign lap_neg   = -lap_q;
  assign vdiff     = {{3{nv_q[31]}}, nv_q} - {{3{pv_q[31]}}, pv_q};
  assign vdiff_neg = -vdiff;

  always_comb begin
    if (cmd_i.dp_op == DP_VABS) begin
      neg_d = vdiff[34];
      mag_d = vdiff[34] ? vdiff_neg : vdiff;
    end else begin
      neg_d = lap_q[35];
      mag_d = lap_q[35] ? lap_neg[34:0] : lap_q[34:0];
    end
  end

  always_comb begin
    case ({cmd_i.fsel_vel, cmd_i.dp_op == DP_MUL_HI})
      2'b11: fpart = vscale_q[31:16];
      2'b10: fpart = vscale_q[15:0];
      2'b01: fpart = coeff_q[31:16];
      default: fpart = coeff_q[15:0];
    endcase
  end

  assign prod    = 51'(mag_q) * 51'(fpart);
  assign term_s  = neg_q ? -$signed({4'b0, acc_q[51:16]}) : $signed({4'b0, acc_q[51:16]});
  assign nv_full = $signed({{7{cv_q[31]}}, cv_q, 1'b0}) - $signed({{8{pv_q[31]}}, pv_q})
                 - term_s;
  assign vel_s   = neg_q ? -$signed({4'b0, acc_q}) : $signed({4'b0, acc_q});
  assign vel_res = sat32(vel_s);

  always_ff @(posedge clk_i) begin
    case (cmd_i.dp_op)
      DP_CAPTURE: begin
        cv_q <= rda_q;
        pv_q <= rdb_q;
      end
      DP_SUM_VERT: sum_q <= $signed({rda_q[31], rda_q}) + $signed({rdb_q[31], rdb_q});
      DP_LAP: lap_q <= four_cv - sum4;
      DP_KABS, DP_VABS: begin
        mag_q <= mag_d;
        neg_q <= neg_d;
      end
      DP_MUL_HI: acc_q <= {1'b0, prod};
      DP_MUL_LO: acc_q <= acc_q + 52'(prod[50:16]);
      DP_NEW: nv_q <= sat32({{16{nv_full[39]}}, nv_full});
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      position_o <= on_grid ? rda_q : '0;
      velocity_o <= on_grid ? velrd_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.op        = op_q;
  assign status_o.on_grid   = on_grid;
  assign status_o.border    = (sr_q == '0) || (sc_q == '0) || (sr_q == CW'(GRID_SIDE - 1))
                            || (sc_q == CW'(GRID_SIDE - 1));
  assign status_o.scan_last = (idx_q == IW'(BANK - 1));
  assign status_o.clr_last  = (clr_q == IW'(BANK - 1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni) rot_q != 2'd3)
    else $error("bank rotation left its range");
  a_vel_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.vel_we && !cmd_i.vel_clear) |-> !status_o.border)
    else $error("velocity written for a border node");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");
  a_rotate_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rotate |-> status_o.scan_last)
    else $error("banks rotated before the scan ended");

endmodule

// ===== verif/tb_spring_grid_verlet_step.sv =====
// Self-checking testbench for the spring grid Verlet step block with a built-in predictor.
module tb_spring_grid_verlet_step;
  timeunit 1ns;
  timeprecision 1ps;
  import sgv_pkg::*;

  localparam int SIDE = 16;
  localparam int PLANE_SZ = SIDE * SIDE;
  localparam int COMPONENTS = 2 * PLANE_SZ;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STEP_SETTLE = 5400;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } node_reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sgv_in_if  in_if();
  sgv_out_if out_if();
  sgv_cfg_if cfg_if();

  spring_grid_verlet_step #(.GRID_SIDE(SIDE)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  logic [31:0] pos_bank[3][COMPONENTS];
  logic [31:0] vel_mem[COMPONENTS];
  int unsigned prev_bank_idx;
  logic [31:0] coeff_reg;
  logic [31:0] vscale_reg;
  node_reading_t expected_readings[$];
  int error_count = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;
  longint cycle_count = 0;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint scale_toward_zero(longint v, logic [31:0] f, int sh);
    logic [63:0] mag;
    logic [127:0] prod;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    prod = 128'(mag) * 128'(f);
    prod = prod >> sh;
    return (v < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic void advance_grid();
    int unsigned cb;
    int unsigned nb;
    int i;
    longint cv;
    longint pv;
    longint nsum;
    longint lap;
    longint nv;
    cb = (prev_bank_idx + 1) % 3;
    nb = (prev_bank_idx + 2) % 3;
    for (int a = 0; a < 2; a++) begin
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE; c++) begin
          i = a * PLANE_SZ + r * SIDE + c;
          if (r == 0 || c == 0 || r == SIDE - 1 || c == SIDE - 1) begin
            pos_bank[nb][i] = pos_bank[cb][i];
          end else begin
            cv = longint'($signed(pos_bank[cb][i]));
            pv = longint'($signed(pos_bank[prev_bank_idx][i]));
            nsum = longint'($signed(pos_bank[cb][i - SIDE]))
                 + longint'($signed(pos_bank[cb][i + SIDE]))
                 + longint'($signed(pos_bank[cb][i - 1]))
                 + longint'($signed(pos_bank[cb][i + 1]));
            lap = 4 * cv - nsum;
            nv = longint'($signed(clamp32(2 * cv - pv - scale_toward_zero(lap, coeff_reg, 32))));
            pos_bank[nb][i] = nv[31:0];
            vel_mem[i] = clamp32(scale_toward_zero(nv - pv, vscale_reg, 16));
          end
        end
      end
    end
    prev_bank_idx = cb;
  endfunction

  function automatic void predict_item(logic [1:0] op, int row, int col, bit axis,
                                       logic [31:0] pv, logic [31:0] cv);
    int i;
    node_reading_t rd;
    i = axis * PLANE_SZ + row * SIDE + col;
    case (op)
      OP_LOAD: begin
        pos_bank[prev_bank_idx][i] = pv;
        pos_bank[(prev_bank_idx + 1) % 3][i] = cv;
      end
      OP_STEP: begin
        advance_grid();
      end
      OP_READ: begin
        rd.position = pos_bank[(prev_bank_idx + 1) % 3][i];
        rd.velocity = vel_mem[i];
        expected_readings.push_back(rd);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(10, 60);
    if (roll < 28) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, int row, int col, bit axis,
                           logic [31:0] pv, logic [31:0] cv);
    int gap;
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.row = row[3:0];
    in_if.col = col[3:0];
    in_if.axis = axis;
    in_if.prev_value = pv;
    in_if.curr_value = cv;
    do @(posedge clk_i); while (!in_if.ready);
    predict_item(op, row, col, axis, pv, cv);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_SPRING_COEFF) coeff_reg = value;
    else if (idx == REG_VEL_SCALE) vscale_reg = value;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_results_done();
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    wait_results_done();
    repeat (STEP_SETTLE) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_item(OP_LOAD, 0, 0, 1'b0, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OP_LOAD, 15, 15, 1'b1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_LOAD, 7, 9, 1'b0, 32'hffff_ffff, 32'h0);
    send_item(OP_READ, 0, 0, 1'b0, 32'h0, 32'h0);
    send_item(OP_READ, 15, 15, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_UNUSED, 7, 9, 1'b0, 32'h1234_5678, 32'h8765_4321);
    send_item(OP_READ, 7, 9, 1'b0, 32'h0, 32'h0);
  endtask

  task automatic test_fill_grid();
    for (int a = 0; a < 2; a++)
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++)
          send_item(OP_LOAD, r, c, a[0],
                    32'($urandom_range(0, 2097152)) - 32'd1048576,
                    32'($urandom_range(0, 2097152)) - 32'd1048576);
  endtask

  task automatic test_directed_step();
    send_item(OP_STEP, 0, 0, 1'b0, 32'h0, 32'h0);
    send_item(OP_READ, 5, 5, 1'b0, 32'h0, 32'h0);
    send_item(OP_READ, 0, 7, 1'b1, 32'h0, 32'h0);
    settle_block();
    write_register(REG_SPRING_COEFF, 32'hffff_ffff);
    write_register(REG_VEL_SCALE, 32'hffff_ffff);
    send_item(OP_LOAD, 8, 8, 1'b1, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OP_LOAD, 7, 8, 1'b1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_LOAD, 9, 8, 1'b1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_LOAD, 8, 7, 1'b1, 32'h0, 32'h8000_0000);
    send_item(OP_LOAD, 8, 9, 1'b1, 32'h0, 32'h8000_0000);
    send_item(OP_STEP, 0, 0, 1'b0, 32'h0, 32'h0);
    send_item(OP_READ, 8, 8, 1'b1, 32'h0, 32'h0);
    send_item(OP_READ, 7, 8, 1'b1, 32'h0, 32'h0);
    send_item(OP_READ, 15, 0, 1'b0, 32'h0, 32'h0);
  endtask

  task automatic test_random_phase(logic [31:0] coeff, logic [31:0] vscale, int n_items);
    int roll;
    settle_block();
    write_register(REG_SPRING_COEFF, coeff);
    write_register(REG_VEL_SCALE, vscale);
    for (int k = 0; k < n_items; k++) begin
      no_idle = (k < n_items / 5) && coeff[0];
      if (k == n_items / 2) settle_block();
      roll = $urandom_range(0, 99);
      if (roll < 4)
        send_item(OP_STEP, $urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom),
                  $urandom, $urandom);
      else if (roll < 8)
        send_item(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom),
                  $urandom, $urandom);
      else if (roll < 45)
        send_item(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom),
                  pick_position(), pick_position());
      else
        send_item(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom),
                  $urandom, $urandom);
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (no_idle) begin
      out_if.ready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    node_reading_t exp_rd;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: position %h velocity %h", out_if.position, out_if.velocity);
        error_count++;
      end else begin
        exp_rd = expected_readings.pop_front();
        if (out_if.position !== exp_rd.position) begin
          $error("position: expected %h actual %h", exp_rd.position, out_if.position);
          error_count++;
        end
        if (out_if.velocity !== exp_rd.velocity) begin
          $error("velocity: expected %h actual %h", exp_rd.velocity, out_if.velocity);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_spring_grid_verlet_step: FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_LOAD;
    in_if.row = '0;
    in_if.col = '0;
    in_if.axis = 1'b0;
    in_if.prev_value = '0;
    in_if.curr_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SPRING_COEFF;
    cfg_if.data = '0;
    coeff_reg = SPRING_COEFF_RST;
    vscale_reg = VEL_SCALE_RST;
    prev_bank_idx = 0;
    for (int i = 0; i < COMPONENTS; i++) begin
      vel_mem[i] = '0;
      for (int b = 0; b < 3; b++) pos_bank[b][i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_fill_grid();
    test_directed_step();
    test_random_phase(SPRING_COEFF_RST, VEL_SCALE_RST, 100);
    test_random_phase(32'h0, 32'h0, 100);
    test_random_phase(32'hffff_ffff, 32'hffff_ffff, 100);
    test_random_phase(32'h8000_0001, 32'h0001_0000, 100);
    test_random_phase($urandom, $urandom, 100);

    settle_block();
    if (error_count == 0) begin
      $display("tb_spring_grid_verlet_step: PASS");
    end else begin
      $display("tb_spring_grid_verlet_step: FAIL");
    end
    $finish;
  end

endmodule
